>>> hdl/hcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcm_pkg;

   // Matrix size, letter width and modulus
   localparam int unsigned Dim        = 3;
   localparam int unsigned EntryBits  = 5;
   localparam int unsigned RowBits    = Dim * EntryBits;
   localparam int unsigned Modulus    = 26;

   // floor(x / 26) == (x * 2521) >> 16 for every x below 2048
   localparam logic [22:0] RECIP_26    = 23'd2521;
   // 26 * 37, keeps a cofactor difference positive without moving its residue
   localparam logic [10:0] COF_OFFSET  = 11'd962;

   // Configuration register indexes
   localparam logic [1:0] REG_KEY_ROW_0 = 2'd0;
   localparam logic [1:0] REG_KEY_ROW_1 = 2'd1;
   localparam logic [1:0] REG_KEY_ROW_2 = 2'd2;

   // Reset key: identity matrix
   localparam logic [14:0] KEY_ROW_0_RESET = 15'd1;
   localparam logic [14:0] KEY_ROW_1_RESET = 15'd32;
   localparam logic [14:0] KEY_ROW_2_RESET = 15'd1024;

   // Operation codes
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [EntryBits-1:0] letter_type;
   typedef letter_type [Dim-1:0] vec_type;

   // Decrypt matrix derivation sequence
   typedef enum logic [2:0] {
      ST_COF,
      ST_DET,
      ST_INV,
      ST_SCALE,
      ST_RUN
   } state_type;

   // Payload handed from cell to cell
   typedef struct packed {
      logic    op;
      logic    invalid;
      vec_type letters;
      vec_type acc;
   } stage_type;

   // One decrypt matrix entry written into a cell
   typedef struct packed {
      logic       en;
      logic [1:0] row;
      letter_type value;
   } cell_load_type;

   typedef struct packed {
      logic [1:0]    col_sel;
      cell_load_type ld;
   } key_load_type;

   // Residue modulo 26 of a value below 2048
   function automatic letter_type mod26(input logic [10:0] x);
      logic [22:0] prod;
      logic [6:0]  q;
      logic [10:0] r;
      prod = 23'(x) * RECIP_26;
      q    = prod[22:16];
      r    = x - 11'(11'(q) * 11'(Modulus));
      return r[EntryBits-1:0];
   endfunction

   // Multiplicative inverse modulo 26, zero where none exists
   function automatic letter_type inv26(input letter_type d);
      letter_type r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hdl/hcm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hcm_cell
   import hcm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          in_valid,
   input  wire stage_type     stage_in,
   input  wire vec_type       enc_col,
   input  wire cell_load_type load,
   output logic               out_valid,
   output stage_type          stage_out
);

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in_next;
   vec_type   dec_col_ff;
   vec_type   col;

   // Store one column of the decrypt matrix
   always_ff @(posedge clock) begin
      if (load.en) begin
         dec_col_ff[load.row] <= load.value;
      end
   end

   // Multiply the column by the head letter and fold into the partial sums
   always_comb begin
      col = (stage_in.op == OP_DECRYPT) ? dec_col_ff : enc_col;
      stage_in_next.op      = stage_in.op;
      stage_in_next.invalid = stage_in.invalid;
      stage_in_next.letters = {letter_type'(0), stage_in.letters[Dim-1:1]};
      for (int r = 0; r < Dim; r++) begin
         stage_in_next.acc[r] = mod26(11'(stage_in.acc[r]) +
                                      11'(col[r] * stage_in.letters[0]));
      end
   end

   // Hold while the next cell is stalled, advance otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in_next;
      end
   end

   assign out_valid = valid_ff;
   assign stage_out = stage_ff;

endmodule

`default_nettype wire

>>> hdl/hcm_keygen.sv
`timescale 1ns / 1ps
`default_nettype none

module hcm_keygen
   import hcm_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                restart,
   input  wire logic [2:0][2:0][4:0] key,
   output logic                     ready,
   output logic                     invalid,
   output key_load_type             load
);

   state_type  state_ff, state_in;
   logic [1:0] hi_ff, hi_in;
   logic [1:0] lo_ff, lo_in;
   letter_type det_ff, det_in;
   letter_type inv_ff;
   logic       invalid_ff;
   letter_type cof_ff [3][3];
   letter_type cof_in;
   logic       last9;
   logic [1:0] hi_p1, hi_p2, lo_p1, lo_p2;

   function automatic logic [1:0] inc3(input logic [1:0] v);
      logic [1:0] r;
      case (v)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   assign last9 = (hi_ff == 2'd2) && (lo_ff == 2'd2);
   assign hi_p1 = inc3(hi_ff);
   assign hi_p2 = inc3(hi_p1);
   assign lo_p1 = inc3(lo_ff);
   assign lo_p2 = inc3(lo_p1);

   // Next state
   always_comb begin
      state_in = state_ff;
      if (restart) begin
         state_in = ST_COF;
      end else begin
         case (state_ff)
            ST_COF:   if (last9) state_in = ST_DET;
            ST_DET:   if (lo_ff == 2'd2) state_in = ST_INV;
            ST_INV:   state_in = ST_SCALE;
            ST_SCALE: if (last9) state_in = ST_RUN;
            ST_RUN:   state_in = ST_RUN;
            default:  state_in = ST_COF;
         endcase
      end
   end

   // Step the entry counters
   always_comb begin
      hi_in = 2'd0;
      lo_in = 2'd0;
      if (!restart) begin
         case (state_ff)
            ST_COF, ST_SCALE: begin
               if (!last9) begin
                  lo_in = lo_p1;
                  hi_in = (lo_ff == 2'd2) ? hi_p1 : hi_ff;
               end
            end
            ST_DET: begin
               if (lo_ff != 2'd2) begin
                  lo_in = lo_p1;
               end
            end
            default: begin
               hi_in = 2'd0;
               lo_in = 2'd0;
            end
         endcase
      end
   end

   // Cofactor of row hi, column lo, and the running determinant
   always_comb begin
      cof_in = mod26(11'(key[hi_p1][lo_p1] * key[hi_p2][lo_p2]) + COF_OFFSET
                     - 11'(key[hi_p1][lo_p2] * key[hi_p2][lo_p1]));
      det_in = det_ff;
      if (state_ff == ST_COF) begin
         det_in = '0;
      end else if (state_ff == ST_DET) begin
         det_in = mod26(11'(det_ff) + 11'(key[0][lo_ff] * cof_ff[0][lo_ff]));
      end
   end

   // Outputs
   always_comb begin
      ready         = (state_ff == ST_RUN);
      invalid       = invalid_ff;
      load.col_sel  = hi_ff;
      load.ld.en    = (state_ff == ST_SCALE);
      load.ld.row   = lo_ff;
      load.ld.value = mod26(11'(cof_ff[hi_ff][lo_ff] * inv_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COF;
         hi_ff    <= 2'd0;
         lo_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
      if (state_ff == ST_COF) begin
         cof_ff[hi_ff][lo_ff] <= cof_in;
      end
      if (state_ff == ST_INV) begin
         inv_ff     <= inv26(det_ff);
         invalid_ff <= (inv26(det_ff) == '0);
      end
   end

   // A restart always leaves the block busy in the cycle after it
   a_restart_busy: assert property (@(posedge clock) disable iff (reset)
      restart |=> !ready)
      else $error("keygen ready right after restart");

   // No matrix entry is written once the key is ready
   a_run_quiet: assert property (@(posedge clock) disable iff (reset)
      ready |-> !load.ld.en)
      else $error("load while ready");

   // Scaling always follows the inverse step
   a_scale_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INV) && !restart |=> (state_ff == ST_SCALE))
      else $error("inverse not followed by scale");

endmodule

`default_nettype wire

>>> hdl/hill_cipher_3x3_mod26.sv
`timescale 1ns / 1ps
`default_nettype none

// Hill cipher with a 3x3 key, modulo 26.
// req_ carries one three-letter block per transfer with the operation in
// tuser (0 encrypt, 1 decrypt); rsp_ returns one block per request, in order,
// with key_invalid in tuser for a decrypt under a key whose determinant has
// no inverse modulo 26 (the letters are then zero).
// csr_ writes the key rows (index 0..2, other indexes ignored); csr_ready is
// always high. Write the key only while no block is in flight.
// After reset and after every key write the key unit derives the decrypt
// matrix (cofactors, determinant, inverse, scaling), one entry per cycle;
// req_tready stays low meanwhile. The reset key is the identity.
// Datapath: a chain of three cells, one per key column, each adding its
// column times one letter to the partial sums; rsp_tvalid rises once the
// request has passed through all three cell registers; one block per cycle
// sustained while the receiver keeps rsp_tready high.
// When the receiver stalls, each cell holds only if the next one is full, so
// empty cells keep filling; req_tready drops once all three are full.
module hill_cipher_3x3_mod26
   import hcm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // letter_0, letter_1, letter_2, pad
   input  wire logic [0:0]  req_tuser,  // operation
   // Response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // out_0, out_1, out_2, pad
   output logic [0:0]       rsp_tuser,  // key_invalid
   // Key register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   logic [Dim-1:0][RowBits-1:0] key_row_ff, key_row_in;
   logic [2:0][2:0][4:0]        key;
   logic                        csr_write;
   logic                        kg_ready;
   logic                        kg_invalid;
   key_load_type                kg_load;
   stage_type                   chain [Dim+1];
   logic [Dim:0]                valid_c;
   logic [Dim:0]                adv;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Key register writes
   always_comb begin
      key_row_in = key_row_ff;
      if (csr_write) begin
         case (csr_index)
            REG_KEY_ROW_0: key_row_in[0] = csr_data;
            REG_KEY_ROW_1: key_row_in[1] = csr_data;
            REG_KEY_ROW_2: key_row_in[2] = csr_data;
            default:       key_row_in = key_row_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_row_ff[0] <= KEY_ROW_0_RESET;
         key_row_ff[1] <= KEY_ROW_1_RESET;
         key_row_ff[2] <= KEY_ROW_2_RESET;
      end else begin
         key_row_ff <= key_row_in;
      end
   end

   // Split rows into entries
   for (genvar r = 0; r < Dim; r++) begin : g_key_row
      for (genvar c = 0; c < Dim; c++) begin : g_key_col
         assign key[r][c] = key_row_ff[r][c*EntryBits +: EntryBits];
      end
   end

   hcm_keygen u_keygen (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_write),
      .key     (key),
      .ready   (kg_ready),
      .invalid (kg_invalid),
      .load    (kg_load)
   );

   // Chain head: fresh request with zero partial sums
   always_comb begin
      chain[0].op         = req_tuser[0];
      chain[0].invalid    = (req_tuser[0] == OP_DECRYPT) && kg_invalid;
      chain[0].letters[0] = req_tdata[4:0];
      chain[0].letters[1] = req_tdata[9:5];
      chain[0].letters[2] = req_tdata[14:10];
      chain[0].acc        = '0;
   end

   assign valid_c[0] = req_tvalid && kg_ready;
   assign adv[Dim]   = rsp_tready;
   assign req_tready = adv[0] && kg_ready;

   for (genvar k = 0; k < Dim; k++) begin : g_cell
      vec_type       enc_col;
      cell_load_type ld;

      // Advance a cell when it is empty or its neighbor moves
      assign adv[k] = !valid_c[k+1] || adv[k+1];

      for (genvar r = 0; r < Dim; r++) begin : g_enc
         assign enc_col[r] = key[r][k];
      end

      always_comb begin
         ld    = kg_load.ld;
         ld.en = kg_load.ld.en && (kg_load.col_sel == 2'(k));
      end

      hcm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (adv[k]),
         .in_valid  (valid_c[k]),
         .stage_in  (chain[k]),
         .enc_col   (enc_col),
         .load      (ld),
         .out_valid (valid_c[k+1]),
         .stage_out (chain[k+1])
      );
   end

   // Chain tail drives the response
   assign rsp_tvalid = valid_c[Dim];
   assign rsp_tdata  = {1'b0, chain[Dim].acc[2], chain[Dim].acc[1], chain[Dim].acc[0]};
   assign rsp_tuser  = chain[Dim].invalid;

   // An invalid key yields zero letters
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata == 16'd0))
      else $error("invalid key with nonzero letters");

   // Result letters stay in 0..25
   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] < 5'd26) && (rsp_tdata[9:5] < 5'd26)
                     && (rsp_tdata[14:10] < 5'd26))
      else $error("result letter out of range");

   // A key write blocks requests while the decrypt matrix is rebuilt
   a_key_busy: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> !req_tready)
      else $error("request taken during key derivation");

endmodule

`default_nettype wire
